/* rtl/core/blit_texture_address_generator_assert.svh */
// Assertion helpers shared by the blitter address generator.
`ifndef BLIT_TEXTURE_ADDRESS_GENERATOR_ASSERT_SVH
`define BLIT_TEXTURE_ADDRESS_GENERATOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BTAG_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("btag assertion failed");

// Next-cycle implication, checked out of reset.
`define BTAG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("btag assertion failed");

`endif

/* rtl/core/btag_pkg.sv */
package btag_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int ADDR_W = 24;
	localparam int CFG_W = 24;
	localparam int MODE_W = 3;
	localparam int CFG_IDX_W = 3;
	localparam int OUT_W = 56;

	typedef enum logic [MODE_W-1:0] {
		MODE_NONE    = 3'd0,
		MODE_WRAP    = 3'd1,
		MODE_CLAMP   = 3'd2,
		MODE_MIRROR  = 3'd3,
		MODE_STRETCH = 3'd4
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODE            = 3'd0,
		CFG_SRC_RECT_ORIGIN = 3'd1,
		CFG_SRC_RECT_SIZE   = 3'd2,
		CFG_DST_RECT_ORIGIN = 3'd3,
		CFG_DST_RECT_SIZE   = 3'd4,
		CFG_SRC_IMAGE_SIZE  = 3'd5,
		CFG_DST_IMAGE_SIZE  = 3'd6
	} cfg_idx_t;

endpackage

/* rtl/core/blit_texture_address_generator.sv */
// Channel   Dir  Fields (lsb first)
// s_*       in   tdata: col_offset, row_offset
// m_*       out  tdata: write_enable, source_invalid, src_address, dst_address
// cfg_*     in   cfg_index selects the register, cfg_data is written
//
// One item per cycle while the output is not held; the pipelined divider
// gives one quotient bit per stage (wrap, mirror, stretch).
// Reset clears the configuration registers and every stage valid bit.
// A held output freezes all stages together; nothing is lost or repeated.
// Configuration writes are always taken.
`include "blit_texture_address_generator_assert.svh"

module blit_texture_address_generator #(
	parameter int COORD_BITS = btag_pkg::COORD_BITS_DEF,
	localparam int IN_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [IN_W-1:0]                   s_tdata,  // col_offset, row_offset
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// write_enable, source_invalid, src_address, dst_address
	output logic [btag_pkg::OUT_W-1:0]        m_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [btag_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [btag_pkg::CFG_W-1:0]        cfg_data
);

	localparam int C = COORD_BITS;
	localparam int SW = 7 * C + 33;
	localparam int AW = btag_pkg::ADDR_W;
	localparam int PAD = btag_pkg::OUT_W - 2 - 2 * AW;

	logic [btag_pkg::MODE_W-1:0] mode_q;
	logic [btag_pkg::CFG_W-1:0]  src_rect_origin_q, src_rect_size_q;
	logic [btag_pkg::CFG_W-1:0]  dst_rect_origin_q, dst_rect_size_q;
	logic [btag_pkg::CFG_W-1:0]  src_image_size_q, dst_image_size_q;

	logic                en;
	logic                p_vld, d_vld;
	logic [1:0][2*C-1:0] p_dvd, d_quo;
	logic [1:0][C:0]     p_dsr, d_rem;
	logic [SW-1:0]       p_side, d_side;
	logic                o_we, o_bad;
	logic [AW-1:0]       o_saddr, o_daddr;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0;
			src_rect_origin_q <= '0;
			src_rect_size_q <= '0;
			dst_rect_origin_q <= '0;
			dst_rect_size_q <= '0;
			src_image_size_q <= '0;
			dst_image_size_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				btag_pkg::CFG_MODE:            mode_q <= cfg_data[btag_pkg::MODE_W-1:0];
				btag_pkg::CFG_SRC_RECT_ORIGIN: src_rect_origin_q <= cfg_data;
				btag_pkg::CFG_SRC_RECT_SIZE:   src_rect_size_q <= cfg_data;
				btag_pkg::CFG_DST_RECT_ORIGIN: dst_rect_origin_q <= cfg_data;
				btag_pkg::CFG_DST_RECT_SIZE:   dst_rect_size_q <= cfg_data;
				btag_pkg::CFG_SRC_IMAGE_SIZE:  src_image_size_q <= cfg_data;
				btag_pkg::CFG_DST_IMAGE_SIZE:  dst_image_size_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// advance every stage unless a finished item is held at the output
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	btag_prep #(.C(C)) u_prep (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(s_tvalid),
		.col(s_tdata[C-1:0]), .row(s_tdata[2*C-1:C]),
		.mode(mode_q),
		.src_rect_origin(src_rect_origin_q), .src_rect_size(src_rect_size_q),
		.dst_rect_origin(dst_rect_origin_q), .dst_rect_size(dst_rect_size_q),
		.src_image_size(src_image_size_q), .dst_image_size(dst_image_size_q),
		.out_vld(p_vld), .dvd(p_dvd), .dsr(p_dsr), .side(p_side)
	);

	btag_div #(.C(C), .SW(SW)) u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(p_vld),
		.dvd(p_dvd), .dsr(p_dsr), .side(p_side),
		.out_vld(d_vld), .rem(d_rem), .quo(d_quo), .side_o(d_side)
	);

	btag_map #(.C(C)) u_map (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(d_vld),
		.rem(d_rem), .quo(d_quo), .side(d_side),
		.out_vld(m_tvalid), .we(o_we), .bad(o_bad),
		.saddr(o_saddr), .daddr(o_daddr)
	);

	assign m_tdata = {PAD'(0), o_daddr, o_saddr, o_bad, o_we};

	`BTAG_ASSERT_NOW(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready)
	`BTAG_ASSERT_NOW(a_we_needs_source, m_tvalid && m_tdata[0], !m_tdata[1])
	`BTAG_ASSERT_NOW(a_bad_zero_addr, m_tvalid && m_tdata[1], m_tdata[25:2] == '0)

endmodule

/* rtl/core/btag_div.sv */
// Two-lane restoring divider, one quotient bit per stage.
module btag_div #(
	parameter int C = btag_pkg::COORD_BITS_DEF,
	parameter int SW = 7 * C + 33
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_vld,
	input  logic [1:0][2*C-1:0]       dvd,
	input  logic [1:0][C:0]           dsr,
	input  logic [SW-1:0]             side,
	output logic                      out_vld,
	output logic [1:0][C:0]           rem,
	output logic [1:0][2*C-1:0]       quo,
	output logic [SW-1:0]             side_o
);

	localparam int N = 2 * C;

	// index 0 is the stage input, index k+1 the register after stage k
	logic [N:0]                  vld_s2;
	logic [N:0][1:0][2*C-1:0]    dvd_s2;
	logic [N:0][1:0][2*C-1:0]    quo_s2;
	logic [N:0][1:0][C:0]        rem_s2;
	logic [N:0][1:0][C:0]        dsr_s2;
	logic [N:0][SW-1:0]          side_s2;

	assign vld_s2[0] = in_vld;
	assign dvd_s2[0] = dvd;
	assign quo_s2[0] = '0;
	assign rem_s2[0] = '0;
	assign dsr_s2[0] = dsr;
	assign side_s2[0] = side;

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [1:0][2*C-1:0] dvd_nx;
		logic [1:0][2*C-1:0] quo_nx;
		logic [1:0][C:0]     rem_nx;

		always_comb begin
			logic [C+1:0] trial;
			logic [C+1:0] diff;
			logic         ge;
			for (int i = 0; i < 2; i++) begin
				trial = {rem_s2[k][i], dvd_s2[k][i][2*C-1]};
				diff = trial - {1'b0, dsr_s2[k][i]};
				ge = trial >= {1'b0, dsr_s2[k][i]};
				rem_nx[i] = ge ? diff[C:0] : trial[C:0];
				quo_nx[i] = {quo_s2[k][i][2*C-2:0], ge};
				dvd_nx[i] = {dvd_s2[k][i][2*C-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s2[k+1] <= 1'b0;
			end else if (en) begin
				vld_s2[k+1] <= vld_s2[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dvd_s2[k+1] <= dvd_nx;
				quo_s2[k+1] <= quo_nx;
				rem_s2[k+1] <= rem_nx;
				dsr_s2[k+1] <= dsr_s2[k];
				side_s2[k+1] <= side_s2[k];
			end
		end
	end

	assign out_vld = vld_s2[N];
	assign rem = rem_s2[N];
	assign quo = quo_s2[N];
	assign side_o = side_s2[N];

endmodule

/* rtl/core/btag_prep.sv */
// Operand stage: unpack registers, form dividends, destination product.
module btag_prep #(
	parameter int C = btag_pkg::COORD_BITS_DEF,
	localparam int SW = 7 * C + 33
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_vld,
	input  logic [C-1:0]                      col,
	input  logic [C-1:0]                      row,
	input  logic [btag_pkg::MODE_W-1:0]       mode,
	input  logic [btag_pkg::CFG_W-1:0]        src_rect_origin,
	input  logic [btag_pkg::CFG_W-1:0]        src_rect_size,
	input  logic [btag_pkg::CFG_W-1:0]        dst_rect_origin,
	input  logic [btag_pkg::CFG_W-1:0]        dst_rect_size,
	input  logic [btag_pkg::CFG_W-1:0]        src_image_size,
	input  logic [btag_pkg::CFG_W-1:0]        dst_image_size,
	output logic                              out_vld,
	output logic [1:0][2*C-1:0]               dvd,
	output logic [1:0][C:0]                   dsr,
	output logic [SW-1:0]                     side
);

	typedef struct packed {
		logic [C-1:0] o;
		logic [C-1:0] n;
		logic [C:0]   sum;
		logic         zbad;
	} ax_t;

	typedef struct packed {
		logic [btag_pkg::MODE_W-1:0] mode;
		ax_t [1:0]                   ax;
		logic                        we_pre;
		logic [btag_pkg::ADDR_W-1:0] dprod;
		logic [C:0]                  desx;
	} side_t;

	logic [1:0][C-1:0] o, d, r, n, w;
	logic [C-1:0]      dox, doy, diw, dih;
	logic [C:0]        desx, desy;
	logic [2*C:0]      dfull;
	side_t             side_nx;
	logic [1:0][2*C-1:0] dvd_nx;
	logic [1:0][C:0]     dsr_nx;

	logic                vld_s1;
	logic [1:0][2*C-1:0] dvd_s1;
	logic [1:0][C:0]     dsr_s1;
	side_t               side_s1;

	assign o[0] = src_rect_origin[C-1:0];
	assign o[1] = C'(src_rect_origin >> C);
	assign r[0] = src_rect_size[C-1:0];
	assign r[1] = C'(src_rect_size >> C);
	assign n[0] = src_image_size[C-1:0];
	assign n[1] = C'(src_image_size >> C);
	assign w[0] = dst_rect_size[C-1:0];
	assign w[1] = C'(dst_rect_size >> C);
	assign d[0] = col;
	assign d[1] = row;
	assign dox = dst_rect_origin[C-1:0];
	assign doy = C'(dst_rect_origin >> C);
	assign diw = dst_image_size[C-1:0];
	assign dih = C'(dst_image_size >> C);

	assign desx = {1'b0, dox} + {1'b0, col};
	assign desy = {1'b0, doy} + {1'b0, row};
	assign dfull = (2*C+1)'(desy) * (2*C+1)'(diw);

	always_comb begin
		logic [C:0]     sum;
		logic [2*C-1:0] prod;
		side_nx.mode = mode;
		side_nx.we_pre = (col < w[0]) && (row < w[1]) && (desx < {1'b0, diw})
			&& (desy < {1'b0, dih});
		side_nx.dprod = btag_pkg::ADDR_W'(dfull);
		side_nx.desx = desx;
		for (int i = 0; i < 2; i++) begin
			sum = {1'b0, o[i]} + {1'b0, d[i]};
			prod = (2*C)'(d[i]) * (2*C)'(r[i]);
			side_nx.ax[i].o = o[i];
			side_nx.ax[i].n = n[i];
			side_nx.ax[i].sum = sum;
			case (mode)
				btag_pkg::MODE_WRAP: begin
					dvd_nx[i] = (2*C)'(d[i]);
					dsr_nx[i] = {1'b0, r[i]};
					side_nx.ax[i].zbad = (r[i] == '0);
				end
				btag_pkg::MODE_CLAMP: begin
					dvd_nx[i] = prod;
					dsr_nx[i] = {1'b0, w[i]};
					side_nx.ax[i].zbad = (n[i] == '0);
				end
				btag_pkg::MODE_MIRROR: begin
					// fold over twice the image size
					dvd_nx[i] = (2*C)'(sum);
					dsr_nx[i] = {n[i], 1'b0};
					side_nx.ax[i].zbad = (n[i] == '0);
				end
				btag_pkg::MODE_STRETCH: begin
					dvd_nx[i] = prod;
					dsr_nx[i] = {1'b0, w[i]};
					side_nx.ax[i].zbad = (w[i] == '0) || (n[i] == '0);
				end
				default: begin
					dvd_nx[i] = prod;
					dsr_nx[i] = {1'b0, w[i]};
					side_nx.ax[i].zbad = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dvd_s1 <= dvd_nx;
			dsr_s1 <= dsr_nx;
			side_s1 <= side_nx;
		end
	end

	assign out_vld = vld_s1;
	assign dvd = dvd_s1;
	assign dsr = dsr_s1;
	assign side = side_s1;

endmodule

/* rtl/core/btag_map.sv */
// Coordinate select per mode, then address multiply and add.
module btag_map #(
	parameter int C = btag_pkg::COORD_BITS_DEF,
	localparam int SW = 7 * C + 33
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_vld,
	input  logic [1:0][C:0]                   rem,
	input  logic [1:0][2*C-1:0]               quo,
	input  logic [SW-1:0]                     side,
	output logic                              out_vld,
	output logic                              we,
	output logic                              bad,
	output logic [btag_pkg::ADDR_W-1:0]       saddr,
	output logic [btag_pkg::ADDR_W-1:0]       daddr
);

	localparam int AW = btag_pkg::ADDR_W;

	typedef struct packed {
		logic [C-1:0] o;
		logic [C-1:0] n;
		logic [C:0]   sum;
		logic         zbad;
	} ax_t;

	typedef struct packed {
		logic [btag_pkg::MODE_W-1:0] mode;
		ax_t [1:0]                   ax;
		logic                        we_pre;
		logic [AW-1:0]               dprod;
		logic [C:0]                  desx;
	} side_t;

	side_t             sd;
	logic [1:0][C-1:0] s_nx;
	logic [1:0]        bad_nx;

	logic              vld_s3, vld_s4, vld_s5;
	logic [1:0][C-1:0] s_s3;
	logic              bad_s3, bad_s4, bad_s5;
	logic              we_s3, we_s4, we_s5;
	logic [C-1:0]      siw_s3;
	logic [AW-1:0]     dprod_s3;
	logic [C:0]        desx_s3;
	logic [C-1:0]      sx_s4;
	logic [AW-1:0]     sprod_s4, daddr_s4, saddr_s5, daddr_s5;

	assign sd = side;

	always_comb begin
		logic [C:0]   n1;
		logic [C:0]   t;
		logic [C:0]   fold;
		logic [2*C:0] ts;
		for (int i = 0; i < 2; i++) begin
			n1 = {1'b0, sd.ax[i].n} - (C+1)'(1);
			t = {1'b0, sd.ax[i].o} + {1'b0, rem[i][C-1:0]};
			fold = {sd.ax[i].n, 1'b0} - (C+1)'(1) - rem[i];
			ts = (2*C+1)'(sd.ax[i].o) + (2*C+1)'(quo[i]);
			case (sd.mode)
				btag_pkg::MODE_WRAP: begin
					s_nx[i] = t[C-1:0];
					bad_nx[i] = sd.ax[i].zbad || (t >= {1'b0, sd.ax[i].n});
				end
				btag_pkg::MODE_CLAMP: begin
					s_nx[i] = (sd.ax[i].sum > n1) ? n1[C-1:0] : sd.ax[i].sum[C-1:0];
					bad_nx[i] = sd.ax[i].zbad;
				end
				btag_pkg::MODE_MIRROR: begin
					s_nx[i] = (rem[i] < {1'b0, sd.ax[i].n}) ? rem[i][C-1:0] : fold[C-1:0];
					bad_nx[i] = sd.ax[i].zbad;
				end
				btag_pkg::MODE_STRETCH: begin
					s_nx[i] = (ts > (2*C+1)'(n1)) ? n1[C-1:0] : ts[C-1:0];
					bad_nx[i] = sd.ax[i].zbad;
				end
				default: begin
					s_nx[i] = sd.ax[i].sum[C-1:0];
					bad_nx[i] = sd.ax[i].sum >= {1'b0, sd.ax[i].n};
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s3 <= in_vld;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s3 <= s_nx;
			bad_s3 <= |bad_nx;
			we_s3 <= sd.we_pre;
			siw_s3 <= sd.ax[0].n;
			dprod_s3 <= sd.dprod;
			desx_s3 <= sd.desx;

			sx_s4 <= s_s3[0];
			sprod_s4 <= AW'((2*C)'(s_s3[1]) * (2*C)'(siw_s3));
			daddr_s4 <= dprod_s3 + AW'(desx_s3);
			bad_s4 <= bad_s3;
			we_s4 <= we_s3 && !bad_s3;

			// invalid source reads as address zero
			saddr_s5 <= bad_s4 ? '0 : (sprod_s4 + AW'(sx_s4));
			daddr_s5 <= daddr_s4;
			bad_s5 <= bad_s4;
			we_s5 <= we_s4;
		end
	end

	assign out_vld = vld_s5;
	assign we = we_s5;
	assign bad = bad_s5;
	assign saddr = saddr_s5;
	assign daddr = daddr_s5;

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;

	typedef struct packed {
		logic [23:0] dst;
		logic [23:0] src;
		logic        inv;
		logic        we;
	} addr_pair_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;  // col_offset, row_offset
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;       // write_enable, source_invalid, src_address, dst_address
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [23:0] cfg_data = '0;

	logic [23:0] regs[7];
	logic [23:0] pixel_q[$];
	addr_pair_t  addr_q[$];
	int          send_idle = 0;
	int          recv_stall = 0;
	bit          hold_en = 0;
	int          hold_cnt = 0;
	int          errs = 0;
	int          wd_cnt = 0;

	blit_texture_address_generator i_dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic bit [63:0] map_coord(logic [2:0] m, bit [63:0] o, bit [63:0] d,
			bit [63:0] r, bit [63:0] n, bit [63:0] w, inout bit bad);
		bit [63:0] s;
		bit [63:0] c;
		case (m)
			btag_pkg::MODE_WRAP: begin
				if (r == 0) begin
					bad = 1;
					return 0;
				end
				s = o + d % r;
				if (s >= n) bad = 1;
				return s;
			end
			btag_pkg::MODE_CLAMP: begin
				if (n == 0) begin
					bad = 1;
					return 0;
				end
				s = o + d;
				return (s > n - 1) ? n - 1 : s;
			end
			btag_pkg::MODE_MIRROR: begin
				if (n == 0) begin
					bad = 1;
					return 0;
				end
				c = (o + d) % (2 * n);
				return (c < n) ? c : 2 * n - 1 - c;
			end
			btag_pkg::MODE_STRETCH: begin
				if (w == 0 || n == 0) begin
					bad = 1;
					return 0;
				end
				s = o + (d * r) / w;
				return (s > n - 1) ? n - 1 : s;
			end
			default: begin
				s = o + d;
				if (s >= n) bad = 1;
				return s;
			end
		endcase
	endfunction

	function automatic addr_pair_t blit_addr(logic [23:0] pix);
		addr_pair_t r;
		bit        bad;
		bit [63:0] col, row, sx, sy, desx, desy;
		bit [63:0] dw, dh, siw, sih, diw, dih;
		bad  = 0;
		col  = pix[11:0];
		row  = pix[23:12];
		dw   = regs[btag_pkg::CFG_DST_RECT_SIZE][11:0];
		dh   = regs[btag_pkg::CFG_DST_RECT_SIZE][23:12];
		siw  = regs[btag_pkg::CFG_SRC_IMAGE_SIZE][11:0];
		sih  = regs[btag_pkg::CFG_SRC_IMAGE_SIZE][23:12];
		diw  = regs[btag_pkg::CFG_DST_IMAGE_SIZE][11:0];
		dih  = regs[btag_pkg::CFG_DST_IMAGE_SIZE][23:12];
		desx = regs[btag_pkg::CFG_DST_RECT_ORIGIN][11:0] + col;
		desy = regs[btag_pkg::CFG_DST_RECT_ORIGIN][23:12] + row;
		sx = map_coord(regs[btag_pkg::CFG_MODE][2:0],
			regs[btag_pkg::CFG_SRC_RECT_ORIGIN][11:0], col,
			regs[btag_pkg::CFG_SRC_RECT_SIZE][11:0], siw, dw, bad);
		sy = map_coord(regs[btag_pkg::CFG_MODE][2:0],
			regs[btag_pkg::CFG_SRC_RECT_ORIGIN][23:12], row,
			regs[btag_pkg::CFG_SRC_RECT_SIZE][23:12], sih, dh, bad);
		r.inv = bad;
		r.src = bad ? 24'd0 : 24'(sy * siw + sx);
		r.we  = !bad && col < dw && row < dh && desx < diw && desy < dih;
		r.dst = 24'(desy * diw + desx);
		return r;
	endfunction

	// driver: predict on acceptance, then offer the next item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) addr_q.push_back(blit_addr(s_tdata));
			if (!s_tvalid || s_tready) begin
				if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle) begin
					s_tdata  <= pixel_q.pop_front();
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (hold_en && hold_cnt < 200) hold_cnt <= hold_cnt + 1;
		m_tready <= !(hold_en && hold_cnt < 200) && $urandom_range(99) >= recv_stall;
	end

	// monitor
	always @(posedge clk) begin
		addr_pair_t exp_r;
		addr_pair_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[49:0];
			if (addr_q.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errs++;
			end else begin
				exp_r = addr_q.pop_front();
				if (got.we !== exp_r.we) begin
					$display("%0t: write_enable exp %h got %h", $time, exp_r.we, got.we);
					errs++;
				end
				if (got.inv !== exp_r.inv) begin
					$display("%0t: source_invalid exp %h got %h", $time, exp_r.inv, got.inv);
					errs++;
				end
				if (got.src !== exp_r.src) begin
					$display("%0t: src_address exp %h got %h", $time, exp_r.src, got.src);
					errs++;
				end
				if (got.dst !== exp_r.dst) begin
					$display("%0t: dst_address exp %h got %h", $time, exp_r.dst, got.dst);
					errs++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				wd_cnt <= 0;
			else
				wd_cnt <= wd_cnt + 1;
			if (wd_cnt == 5000) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	task automatic write_reg(btag_pkg::cfg_idx_t idx, logic [23:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		regs[idx] = (idx == btag_pkg::CFG_MODE) ? {21'd0, val[2:0]} : val;
	endtask

	task automatic drain();
		do @(posedge clk); while (pixel_q.size() > 0 || s_tvalid || addr_q.size() > 0);
		repeat (32) @(posedge clk);
	endtask

	function automatic logic [11:0] rnd_coord();
		case ($urandom_range(9))
			0: return 12'd0;
			1: return 12'hFFF;
			2: return 12'($urandom_range(4095));
			default: return 12'($urandom_range(1, 64));
		endcase
	endfunction

	task automatic set_all(logic [2:0] m, logic [23:0] so, logic [23:0] ss,
			logic [23:0] dro, logic [23:0] ds, logic [23:0] si, logic [23:0] di);
		write_reg(btag_pkg::CFG_MODE, {21'($urandom), m});
		write_reg(btag_pkg::CFG_SRC_RECT_ORIGIN, so);
		write_reg(btag_pkg::CFG_SRC_RECT_SIZE, ss);
		write_reg(btag_pkg::CFG_DST_RECT_ORIGIN, dro);
		write_reg(btag_pkg::CFG_DST_RECT_SIZE, ds);
		write_reg(btag_pkg::CFG_SRC_IMAGE_SIZE, si);
		write_reg(btag_pkg::CFG_DST_IMAGE_SIZE, di);
	endtask

	task automatic push_corners();
		pixel_q.push_back({12'd0, 12'd0});
		pixel_q.push_back({12'hFFF, 12'hFFF});
		pixel_q.push_back({12'd0, 12'hFFF});
		pixel_q.push_back({12'd5, 12'd3});
	endtask

	initial begin
		logic [11:0] dw, dh;
		foreach (regs[i]) regs[i] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset configuration: every size is zero, source invalid
		push_corners();
		drain();
		// stretch mode with every other register at the top of its range
		set_all(btag_pkg::MODE_STRETCH, '1, '1, '1, '1, '1, '1);
		push_corners();
		drain();
		// each mode on a small picture, offsets past the rectangle and image edges
		for (int m = btag_pkg::MODE_NONE; m <= btag_pkg::MODE_STRETCH; m++) begin
			set_all(3'(m), {12'd2, 12'd3}, {12'd4, 12'd5}, {12'd1, 12'd2},
				{12'd6, 12'd8}, {12'd7, 12'd6}, {12'd9, 12'd10});
			push_corners();
			drain();
		end

		for (int p = 0; p < 16; p++) begin
			set_all(3'($urandom_range(7)), {rnd_coord(), rnd_coord()},
				{rnd_coord(), rnd_coord()}, {rnd_coord(), rnd_coord()},
				{rnd_coord(), rnd_coord()}, {rnd_coord(), rnd_coord()},
				{rnd_coord(), rnd_coord()});
			case (p % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 52; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 52; end
				default: begin send_idle = 13; recv_stall = 13; end
			endcase
			// hold the output long enough to back up the pipeline
			if (p == 4) hold_en = 1;
			dw = regs[btag_pkg::CFG_DST_RECT_SIZE][11:0];
			dh = regs[btag_pkg::CFG_DST_RECT_SIZE][23:12];
			for (int i = 0; i < 105; i++) begin
				if ($urandom_range(3) == 0)
					pixel_q.push_back(24'($urandom));
				else
					pixel_q.push_back({12'($urandom_range(0, int'(dh) + 2)),
						12'($urandom_range(0, int'(dw) + 2))});
			end
			drain();
			hold_en = 0;
		end

		if (errs == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
